[rtl/gf2m_poly_multiplier_unit_macros.svh]
// Assertion macros for the GF(2^m) multiplier checker.
`ifndef GF2M_POLY_MULTIPLIER_UNIT_MACROS_SVH
`define GF2M_POLY_MULTIPLIER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GFPM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GFPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/gfpm_pkg.sv]
// Shared types and constants for the GF(2^m) polynomial-basis multiplier.
`timescale 1ns / 1ps
`default_nettype none

package gfpm_pkg;

    localparam int OPERAND_W       = 16;
    localparam int PRODUCT_W       = 16;
    localparam int POLY_W          = 17;
    localparam int DEGREE_W        = 5;
    localparam int CFG_DATA_W      = 17;
    localparam int STEPS_PER_STAGE = 8;

    typedef logic [OPERAND_W-1:0]  operand_t;
    typedef logic [PRODUCT_W-1:0]  product_t;
    typedef logic [POLY_W-1:0]     poly_t;
    typedef logic [DEGREE_W-1:0]   degree_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    typedef enum logic [0:0]
    {
        REG_FIELD_POLYNOMIAL = 1'b0,
        REG_FIELD_DEGREE     = 1'b1
    } cfg_reg_t;

    localparam poly_t   POLY_RESET   = 17'd13;
    localparam degree_t DEGREE_RESET = 5'd3;

endpackage

`default_nettype wire

[rtl/gfpm_if.sv]
// Valid/ready channel interfaces for operand pairs and products.
`timescale 1ns / 1ps
`default_nettype none

interface gfpm_opnd_if;
    import gfpm_pkg::*;

    logic     valid;
    logic     ready;
    operand_t operand_a;
    operand_t operand_b;

    modport source (output valid, output operand_a, output operand_b, input ready);
    modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface gfpm_prod_if;
    import gfpm_pkg::*;

    logic     valid;
    logic     ready;
    product_t product;

    modport source (output valid, output product, input ready);
    modport sink   (input valid, input product, output ready);
endinterface

`default_nettype wire

[rtl/gfpm_field_cfg.sv]
// Field configuration registers and the masks and aligned polynomial derived from them.
`timescale 1ns / 1ps
`default_nettype none

module gfpm_field_cfg #(
    parameter int MAX_DEGREE = 16,
    parameter int OPW        = 16,
    parameter int PW         = 31
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  gfpm_pkg::cfg_reg_t  wr_index,
    input  gfpm_pkg::cfg_data_t wr_data,
    output logic [OPW-1:0]      opmask,
    output logic [MAX_DEGREE:0] palign,
    output logic [PW-1:0]       emask,
    output logic [PW-1:0]       rmask
);
    import gfpm_pkg::*;

    localparam int D  = MAX_DEGREE;
    localparam int MW = $clog2(D + 1);
    localparam int CW = (MW > DEGREE_W) ? MW : DEGREE_W;

    poly_t         poly_reg;
    degree_t       degree_reg;
    logic [MW-1:0] m_cur;
    logic [D:0]    palign_reg;
    logic [D:0]    palign_next;
    logic [PW-1:0] rmask_reg;
    logic [PW-1:0] rmask_next;

    function automatic logic [MW-1:0] eff_degree(degree_t deg);
        logic [CW-1:0] dx;
        begin
            dx = CW'(deg);
            priority if (dx < CW'(2))
            begin
                return MW'(2);
            end
            else if (dx > CW'(D))
            begin
                return MW'(D);
            end
            else
            begin
                return MW'(dx);
            end
        end
    endfunction

    // poly restricted to x^0..x^m, shifted so x^m lands on bit D
    function automatic logic [D:0] align_poly(poly_t poly, logic [MW-1:0] m);
        logic [D:0] r;
        begin
            r = '0;
            for (int k = 0; k <= D; k++)
            begin
                for (int s = 0; s < POLY_W; s++)
                begin
                    if ((s == k + int'(m) - D) && (s <= int'(m)))
                    begin
                        r[k] = poly[s];
                    end
                end
            end
            return r;
        end
    endfunction

    function automatic logic [PW-1:0] low_mask(logic [MW-1:0] m);
        logic [PW-1:0] r;
        begin
            for (int j = 0; j < PW; j++)
            begin
                r[j] = (j < int'(m));
            end
            return r;
        end
    endfunction

    always_comb
    begin
        m_cur       = eff_degree(degree_reg);
        palign_next = align_poly(poly_reg, m_cur);
        rmask_next  = low_mask(m_cur);
        for (int j = 0; j < OPW; j++)
        begin
            opmask[j] = (j < int'(m_cur));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg   <= POLY_RESET;
            degree_reg <= DEGREE_RESET;
            palign_reg <= align_poly(POLY_RESET, eff_degree(DEGREE_RESET));
            rmask_reg  <= low_mask(eff_degree(DEGREE_RESET));
        end
        else
        begin
            palign_reg <= palign_next;
            rmask_reg  <= rmask_next;
            if (wr_en)
            begin
                unique case (wr_index)
                    REG_FIELD_POLYNOMIAL: poly_reg   <= wr_data[POLY_W-1:0];
                    REG_FIELD_DEGREE:     degree_reg <= wr_data[DEGREE_W-1:0];
                endcase
            end
        end
    end

    assign palign = palign_reg;
    assign rmask  = rmask_reg;
    assign emask  = ~rmask_reg;

endmodule

`default_nettype wire

[rtl/gfpm_reduce_stage.sv]
// One slice of the long-division reduction: a run of consecutive top-down steps.
`timescale 1ns / 1ps
`default_nettype none

module gfpm_reduce_stage #(
    parameter int MAX_DEGREE = 16,
    parameter int PW         = 31,
    parameter int HI_STEP    = 30,
    parameter int NSTEPS     = 8
) (
    input  logic [PW-1:0]       c_in,
    input  logic [MAX_DEGREE:0] palign,
    input  logic [PW-1:0]       emask,
    output logic [PW-1:0]       c_out
);
    import gfpm_pkg::*;

    logic [PW-1:0] c;
    logic [PW-1:0] term;
    int            i;
    int            k;

    always_comb
    begin
        c = c_in;
        for (int s = 0; s < NSTEPS; s++)
        begin
            i    = HI_STEP - s;
            term = '0;
            for (int j = 0; j < PW; j++)
            begin
                k = j + MAX_DEGREE - i;
                if (k >= 0 && k <= MAX_DEGREE)
                begin
                    term[j] = palign[k];
                end
            end
            if (emask[i] && c[i])
            begin
                c = c ^ term;
            end
        end
        c_out = c;
    end

endmodule

`default_nettype wire

[rtl/gf2m_poly_multiplier_unit.sv]
// Top level: pipelined GF(2^m) polynomial-basis multiplier with configurable field.
//
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+---------------------------------
//  operands  | in  | valid/ready  | operand_a[15:0], operand_b[15:0]
//  result    | out | valid/ready  | product[15:0]
//  config    | in  | wr_en        | wr_index, wr_data[16:0]
//
// The pipeline has PIPE_STAGES stages: one carry-less multiply stage plus
// ceil((2*min(MAX_DEGREE,16)-3)/8) reduction stages of at most eight steps each.
// One transfer per cycle in and out unless result stalls; step chain sets stage depth.
// Reset clears all stage valid bits and loads the reset field (x^3+x^2+1, m = 3).
// Stages advance independently: bubbles close up, and operands.ready drops only
// when every stage is full and the result is held.
// A config write applies to transfers accepted from the next cycle on.
`timescale 1ns / 1ps
`default_nettype none

module gf2m_poly_multiplier_unit #(
    parameter int MAX_DEGREE = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    gfpm_opnd_if.sink           operands,
    gfpm_prod_if.source         result,
    input  logic                wr_en,
    input  gfpm_pkg::cfg_reg_t  wr_index,
    input  gfpm_pkg::cfg_data_t wr_data
);
    import gfpm_pkg::*;

    localparam int OPW         = (MAX_DEGREE < OPERAND_W) ? MAX_DEGREE : OPERAND_W;
    localparam int PW          = 2 * OPW - 1;
    localparam int NSTEP       = PW - 2;
    localparam int NRS         = (NSTEP + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int PIPE_STAGES = NRS + 1;

    logic [OPW-1:0]        opmask;
    logic [MAX_DEGREE:0]   palign;
    logic [PW-1:0]         emask;
    logic [PW-1:0]         rmask;
    logic [OPW-1:0]        a_m;
    logic [OPW-1:0]        b_m;
    logic [PW-1:0]         mul_next;
    logic [PW-1:0]         data_next [PIPE_STAGES];
    logic [PW-1:0]         data_reg  [PIPE_STAGES];
    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES:0]  rdy;
    logic [PW+PRODUCT_W-1:0] prod_wide;

    gfpm_field_cfg #(
        .MAX_DEGREE (MAX_DEGREE),
        .OPW        (OPW),
        .PW         (PW)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .opmask   (opmask),
        .palign   (palign),
        .emask    (emask),
        .rmask    (rmask)
    );

    // carry-less multiply of masked operands
    always_comb
    begin
        a_m      = operands.operand_a[OPW-1:0] & opmask;
        b_m      = operands.operand_b[OPW-1:0] & opmask;
        mul_next = '0;
        for (int i = 0; i < OPW; i++)
        begin
            if (a_m[i])
            begin
                mul_next = mul_next ^ (PW'(b_m) << i);
            end
        end
    end

    assign data_next[0] = mul_next;

    for (genvar k = 1; k <= NRS; k++)
    begin : g_reduce
        localparam int HI = PW - 1 - (k - 1) * STEPS_PER_STAGE;
        localparam int N  = (HI - 1 < STEPS_PER_STAGE) ? HI - 1 : STEPS_PER_STAGE;

        logic [PW-1:0] red;

        gfpm_reduce_stage #(
            .MAX_DEGREE (MAX_DEGREE),
            .PW         (PW),
            .HI_STEP    (HI),
            .NSTEPS     (N)
        ) u_stage (
            .c_in   (data_reg[k-1]),
            .palign (palign),
            .emask  (emask),
            .c_out  (red)
        );

        assign data_next[k] = (k == NRS) ? (red & rmask) : red;
    end

    always_comb
    begin
        rdy[PIPE_STAGES] = result.ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--)
        begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (rdy[0])
            begin
                valid_reg[0] <= operands.valid;
            end
            for (int k = 1; k < PIPE_STAGES; k++)
            begin
                if (rdy[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PIPE_STAGES; k++)
        begin
            if (rdy[k])
            begin
                data_reg[k] <= data_next[k];
            end
        end
    end

    assign prod_wide      = {{PRODUCT_W{1'b0}}, data_reg[PIPE_STAGES-1]};
    assign operands.ready = rdy[0];
    assign result.valid   = valid_reg[PIPE_STAGES-1];
    assign result.product = prod_wide[PRODUCT_W-1:0];

endmodule

`default_nettype wire

[rtl/gfpm_checker.sv]
// Port-level checker for the GF(2^m) multiplier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "gf2m_poly_multiplier_unit_macros.svh"

module gfpm_checker #(
    parameter int DEPTH = 5
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input gfpm_pkg::product_t product
);

    `GFPM_ASSERT_NEXT(a_out_valid_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `GFPM_ASSERT_NEXT(a_out_data_hold, out_valid && !out_ready, $stable(product), "product changed while stalled")
    `GFPM_ASSERT_IMPL(a_ready_with_room, !out_valid || out_ready, in_ready, "input stalled with room in pipe")
    `GFPM_ASSERT_IMPL(a_fill_latency, $rose(out_valid), $past(in_valid && in_ready, DEPTH), "result without matching transfer")

endmodule

bind gf2m_poly_multiplier_unit gfpm_checker #(
    .DEPTH (PIPE_STAGES)
) u_gfpm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .product   (result.product)
);

`default_nettype wire

[sim/gf2m_poly_multiplier_unit_tb.sv]
// Testbench for gf2m_poly_multiplier_unit: directed and random field multiplies checked against a local model.
`timescale 1ns / 1ps

module gf2m_poly_multiplier_unit_tb;
    import gfpm_pkg::*;

    localparam int MAX_DEGREE  = 16;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;

    typedef enum logic
    {
        ROW_OPERANDS = 1'b0,
        ROW_WRITE    = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t kind;
        cfg_reg_t  reg_idx;
        cfg_data_t data;
        operand_t  a;
        operand_t  b;
        logic      known;
        product_t  want;
    } stim_row_t;

    localparam int PLAN_ROWS = 31;
    localparam stim_row_t PLAN [PLAN_ROWS] = '{
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'h0000, 1'b1, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0001, 16'h0005, 1'b1, 16'h0005},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0008, 16'h0003, 1'b1, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0007, 16'h0007, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h1002B, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd16,    16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0001, 16'hFFFF, 1'b1, 16'hFFFF},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h8000, 16'h8000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h00007, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd0,     16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0003, 16'h0003, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'h0002, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd1,     16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0002, 16'h0003, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h1FFFF, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd31,    16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hABCD, 16'h1234, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h0002B, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd17,    16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h8000, 16'h0002, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h1FF1B, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_DEGREE,     17'd8,     16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0053, 16'h00CA, 1'b1, 16'h0001},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{ROW_WRITE,    REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h00FF, 16'h00FF, 1'b0, 16'h0000},
        '{ROW_OPERANDS, REG_FIELD_POLYNOMIAL, 17'h00000, 16'h0080, 16'h0080, 1'b0, 16'h0000}
    };

    logic      clk;
    logic      rst_n;
    logic      wr_en;
    cfg_reg_t  wr_index;
    cfg_data_t wr_data;

    gfpm_opnd_if operands();
    gfpm_prod_if result();

    gf2m_poly_multiplier_unit #(
        .MAX_DEGREE (MAX_DEGREE)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .operands (operands),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    poly_t    cur_poly = POLY_RESET;
    degree_t  cur_deg  = DEGREE_RESET;
    product_t pending_products[$];
    int       mismatches    = 0;
    int       items_sent    = 0;
    int       products_seen = 0;
    int       writes_done   = 0;
    int       cycle_count   = 0;
    int       sink_hold_req = 0;
    bit       steady        = 1'b0;

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d products outstanding",
                     cycle_count, pending_products.size());
            $display("** gf2m_poly_multiplier_unit: FAILED **");
            $finish;
        end
    end

    function automatic int clamp_degree(degree_t deg);
        if (deg < 2)
            return 2;
        if (deg > MAX_DEGREE)
            return MAX_DEGREE;
        return int'(deg);
    endfunction

    // Carry-less multiply, then long division from x^(2m-2) down to x^m.
    function automatic product_t gf_product(operand_t a, operand_t b, poly_t poly,
                                            degree_t deg);
        int          m;
        logic [31:0] mask;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] divisor;
        logic [31:0] acc;
        m       = clamp_degree(deg);
        mask    = (32'd1 << m) - 32'd1;
        pa      = 32'(a) & mask;
        pb      = 32'(b) & mask;
        divisor = 32'(poly) & ((32'd1 << (m + 1)) - 32'd1);
        acc     = '0;
        for (int i = 0; i < m; i++)
            if (pa[i])
                acc ^= pb << i;
        for (int i = 2 * m - 2; i >= m; i--)
            if (acc[i])
                acc ^= divisor << (i - m);
        return product_t'(acc & mask);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic operand_t rand_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return operand_t'(1) << $urandom_range(0, 15);
            3: return (operand_t'(1) << clamp_degree(cur_deg)) - operand_t'(1);
            default: return operand_t'($urandom);
        endcase
    endfunction

    task automatic send_operands(operand_t a, operand_t b, logic known, product_t want,
                                 int gap);
        if (gap > 0)
        begin
            operands.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operands.valid     <= 1'b1;
        operands.operand_a <= a;
        operands.operand_b <= b;
        do
            @(posedge clk);
        while (!operands.ready);
        pending_products.push_back(known ? want : gf_product(a, b, cur_poly, cur_deg));
        items_sent++;
    endtask

    task automatic wait_idle();
        operands.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_products.size() != 0);
    endtask

    // Leaves wr_en high; the caller drops it after the last write.
    task automatic write_reg(cfg_reg_t idx, cfg_data_t data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        if (idx == REG_FIELD_POLYNOMIAL)
            cur_poly = poly_t'(data);
        else
            cur_deg = degree_t'(data);
        writes_done++;
    endtask

    // Product sink: check each transfer, then pick the next ready level.
    initial
    begin
        int stall_left;
        stall_left = 0;
        result.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result.valid && result.ready)
            begin
                products_seen++;
                if (pending_products.size() == 0)
                begin
                    $error("product: transfer with nothing expected, actual %h", result.product);
                    mismatches++;
                end
                else
                begin
                    product_t want;
                    want = pending_products.pop_front();
                    if (result.product !== want)
                    begin
                        $error("product: expected %h, actual %h", want, result.product);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result.ready <= 1'b0;
            end
            else if (sink_hold_req > 0)
            begin
                stall_left    = sink_hold_req - 1;
                sink_hold_req = 0;
                result.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 99) < 20)
            begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                result.ready <= 1'b0;
            end
            else
                result.ready <= 1'b1;
        end
    end

    initial
    begin
        int      m_eff;
        poly_t   p;
        degree_t d;
        bit      burst;
        rst_n              <= 1'b0;
        wr_en              <= 1'b0;
        wr_index           <= REG_FIELD_POLYNOMIAL;
        wr_data            <= '0;
        operands.valid     <= 1'b0;
        operands.operand_a <= '0;
        operands.operand_b <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            if (PLAN[i].kind == ROW_WRITE)
            begin
                if (i == 0 || PLAN[i-1].kind != ROW_WRITE)
                    wait_idle();
                write_reg(PLAN[i].reg_idx, PLAN[i].data);
                if (i == PLAN_ROWS - 1 || PLAN[i+1].kind != ROW_WRITE)
                    wr_en <= 1'b0;
            end
            else
                send_operands(PLAN[i].a, PLAN[i].b, PLAN[i].known, PLAN[i].want,
                              pick_gap());
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: d = 5'd2;
                1: d = 5'd16;
                2: d = 5'd0;
                3: d = 5'd31;
                default: d = ($urandom_range(0, 3) == 0) ? degree_t'($urandom_range(0, 31))
                                                         : degree_t'($urandom_range(2, 16));
            endcase
            m_eff = clamp_degree(d);
            p = poly_t'($urandom_range(0, 17'h1FFFF));
            if ($urandom_range(0, 3) != 0)
                p = p | (poly_t'(1) << m_eff) | poly_t'(1);
            write_reg(REG_FIELD_POLYNOMIAL, cfg_data_t'(p));
            write_reg(REG_FIELD_DEGREE, cfg_data_t'(d));
            wr_en <= 1'b0;
            steady = (ph == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long sink hold against a gapless burst fills the pipeline
                burst = (ph == 3 && k >= 10 && k < 50);
                if (ph == 3 && k == 10)
                    sink_hold_req = 150;
                if (ph == 6 && k == PHASE_ITEMS / 2)
                    wait_idle();
                send_operands(rand_operand(), rand_operand(), 1'b0, '0,
                              burst ? 0 : pick_gap());
            end
            steady = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("%0d operand pairs, %0d products checked, %0d register writes",
                 items_sent, products_seen, writes_done);
        $display("degrees 0..31 incl. clamped, odd polynomials, sink hold and sender pause");
        if (mismatches == 0 && pending_products.size() == 0)
            $display("** gf2m_poly_multiplier_unit: PASSED **");
        else
            $display("** gf2m_poly_multiplier_unit: FAILED **");
        $finish;
    end

endmodule
